// File: hdl/arpc_pkg.sv
// arpc_pkg: shared types and codes for the address cache table
// used by the channel interfaces, the slot cell and the top level
`default_nettype none

package arpc_pkg;

	localparam int unsigned IP_W  = 32;
	localparam int unsigned MAC_W = 48;
	localparam int unsigned OP_W  = 3;
	localparam int unsigned ST_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 3'd0,
		OP_INSERT = 3'd1,
		OP_UPDATE = 3'd2,
		OP_DELETE = 3'd3,
		OP_INIT   = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_PRESENT   = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// configuration register indexes
	typedef enum logic {
		CFG_LOCAL_IP  = 1'b0,
		CFG_LOCAL_MAC = 1'b1
	} cfg_idx_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic             exec;
		op_t              op;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
		logic [IP_W-1:0]  host_ip;
		logic [MAC_W-1:0] host_mac;
	} cell_cmd_t;

	// per-cell compare results back to the control
	typedef struct packed {
		logic             ip_hit;
		logic             del_hit;
		logic             take;
		logic [MAC_W-1:0] mac;
	} cell_stat_t;

endpackage

`default_nettype wire

// File: hdl/arpc_req_if.sv
// arpc_req_if: request channel (valid/ready) carrying one cache operation
// depends on arpc_pkg for field widths
`default_nettype none

interface arpc_req_if import arpc_pkg::*;;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [IP_W-1:0]  ip_addr;
	logic [MAC_W-1:0] mac_addr;

	modport source (output valid, output operation, output ip_addr, output mac_addr,
		input ready);
	modport sink (input valid, input operation, input ip_addr, input mac_addr,
		output ready);
endinterface

`default_nettype wire

// File: hdl/arpc_rsp_if.sv
// arpc_rsp_if: response channel (valid/ready) carrying status and found mac
// depends on arpc_pkg for field widths
`default_nettype none

interface arpc_rsp_if import arpc_pkg::*;;
	logic             valid;
	logic             ready;
	logic [ST_W-1:0]  status;
	logic [MAC_W-1:0] found_mac;

	modport source (output valid, output status, output found_mac, input ready);
	modport sink (input valid, input status, input found_mac, output ready);
endinterface

`default_nettype wire

// File: hdl/arpc_cell.sv
// arpc_cell: one table slot with its own compare and write-back logic
// depends on arpc_pkg; chained to its neighbours through the free-slot ripple
`default_nettype none

module arpc_cell import arpc_pkg::*; #(
	parameter bit IS_LOCAL = 1'b0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_cmd_t  cmd,
	input  logic       any_ip_hit,
	input  logic       free_in,
	output logic       free_out,
	output cell_stat_t stat
);

	logic             valid_q;
	logic [IP_W-1:0]  ip_q;
	logic [MAC_W-1:0] mac_q;
	logic             ip_hit;
	logic             is_free;
	logic             take;

	assign ip_hit   = valid_q && (ip_q == cmd.ip);
	// the local slot never takes part in insert or delete
	assign is_free  = !IS_LOCAL && !valid_q;
	assign take     = is_free && !free_in;
	assign free_out = free_in || is_free;

	assign stat.ip_hit  = ip_hit;
	assign stat.del_hit = !IS_LOCAL && ip_hit && (mac_q == cmd.mac);
	assign stat.take    = take;
	assign stat.mac     = ip_hit ? mac_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.exec) begin
			unique case (cmd.op)
				OP_INIT: begin
					valid_q <= IS_LOCAL;
				end
				OP_INSERT: begin
					if (take && !any_ip_hit) valid_q <= 1'b1;
				end
				OP_DELETE: begin
					if (stat.del_hit) valid_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			unique case (cmd.op)
				OP_INIT: begin
					if (IS_LOCAL) begin
						ip_q  <= cmd.host_ip;
						mac_q <= cmd.host_mac;
					end
				end
				OP_INSERT: begin
					if (take && !any_ip_hit) begin
						ip_q  <= cmd.ip;
						mac_q <= cmd.mac;
					end
				end
				OP_UPDATE: begin
					if (ip_hit) mac_q <= cmd.mac;
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/arp_cache_table_core.sv
// arp_cache_table_core: bounded ipv4-to-mac cache built as a row of slot cells
// depends on arpc_pkg, arpc_req_if, arpc_rsp_if and arpc_cell
`default_nettype none

// The cache holds ENTRIES slots, each a small cell with its own valid bit, ip and mac.
// Slot 0 is the local slot, loaded from the host ip and mac registers by an init and
// never removed by delete. The transfer on the request channel latches the operation
// into the stage-one register; once the output register is free or being emptied,
// every cell compares its ip (and mac for delete) with the key at once, the
// lowest free slot is picked by a ripple that runs from cell to cell, and the cells
// write back while the status and found mac go into the output register. A new
// request is taken as soon as the stage-one register is empty, so one may be
// accepted while the previous response still waits for its transfer. The free-slot
// ripple through all cells sets the length of the compare path. Configuration
// writes are taken at any time and only reach slot 0 on the next init.

module arp_cache_table_core import arpc_pkg::*; #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [MAC_W-1:0] cfg_wdata,
	arpc_req_if.sink         req,
	arpc_rsp_if.source       rsp
);

	// configuration registers
	logic [IP_W-1:0]  host_ip_q;
	logic [MAC_W-1:0] host_mac_q;

	// stage one: the operation under work
	logic             busy_s1;
	op_t              op_s1;
	logic [IP_W-1:0]  ip_s1;
	logic [MAC_W-1:0] mac_s1;

	// output register
	logic             rsp_valid_q;
	status_t          status_q;
	logic [MAC_W-1:0] found_mac_q;

	logic             commit;
	cell_cmd_t        cmd;
	cell_stat_t       stat [ENTRIES];
	logic [ENTRIES:0] free_chain;
	logic [ENTRIES-1:0] ip_hit_vec;
	logic [ENTRIES-1:0] del_hit_vec;
	logic [ENTRIES-1:0] take_vec;
	logic             any_ip_hit;
	logic             any_del_hit;
	logic             any_free;
	logic [MAC_W-1:0] hit_mac;
	status_t          status_d;
	logic [MAC_W-1:0] found_mac_d;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_ip_q  <= '0;
			host_mac_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LOCAL_IP:  host_ip_q  <= cfg_wdata[IP_W-1:0];
				CFG_LOCAL_MAC: host_mac_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// request side: one operation in flight in stage one
	assign req.ready = !busy_s1;
	// stage one finishes once the output register is free or being emptied
	assign commit    = busy_s1 && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			busy_s1 <= 1'b1;
		end else if (commit) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1  <= op_t'(req.operation);
			ip_s1  <= req.ip_addr;
			mac_s1 <= req.mac_addr;
		end
	end

	// broadcast to the cells
	assign cmd.exec     = commit;
	assign cmd.op       = op_s1;
	assign cmd.ip       = ip_s1;
	assign cmd.mac      = mac_s1;
	assign cmd.host_ip  = host_ip_q;
	assign cmd.host_mac = host_mac_q;

	// row of slot cells; the free ripple starts empty at the local slot
	assign free_chain[0] = 1'b0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		arpc_cell #(
			.IS_LOCAL (g == 0)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.any_ip_hit (any_ip_hit),
			.free_in    (free_chain[g]),
			.free_out   (free_chain[g+1]),
			.stat       (stat[g])
		);
		assign ip_hit_vec[g]  = stat[g].ip_hit;
		assign del_hit_vec[g] = stat[g].del_hit;
		assign take_vec[g]    = stat[g].take;
	end

	assign any_ip_hit  = |ip_hit_vec;
	assign any_del_hit = |del_hit_vec;
	assign any_free    = free_chain[ENTRIES];

	// ip addresses stay unique, so at most one cell drives a non-zero mac
	always_comb begin
		hit_mac = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_mac = hit_mac | stat[i].mac;
		end
	end

	// response status
	always_comb begin
		status_d    = ST_NOT_FOUND;
		found_mac_d = '0;
		unique case (op_s1)
			OP_LOOKUP: begin
				if (any_ip_hit) begin
					status_d    = ST_OK;
					found_mac_d = hit_mac;
				end
			end
			OP_INSERT: begin
				if (any_ip_hit) status_d = ST_PRESENT;
				else if (any_free) status_d = ST_OK;
				else status_d = ST_FULL;
			end
			OP_UPDATE: begin
				if (any_ip_hit) status_d = ST_OK;
			end
			OP_DELETE: begin
				if (any_del_hit) status_d = ST_OK;
			end
			OP_INIT: begin
				status_d = ST_OK;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q    <= status_d;
			found_mac_q <= found_mac_d;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.found_mac = found_mac_q;

	// a finished operation always leaves a response behind
	a_commit_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp_valid_q)
		else $error("response missing after commit");

	// ip addresses in the table stay unique
	a_unique_ip: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> $onehot0(ip_hit_vec))
		else $error("more than one slot matches the ip");

	// the free ripple picks exactly one slot whenever one is free
	a_one_take: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> (any_free ? $onehot(take_vec) : (take_vec == '0)))
		else $error("free slot selection broken");

	// the local slot is never a delete target
	a_local_kept: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s1 |-> !del_hit_vec[0])
		else $error("local slot matched for delete");

endmodule

`default_nettype wire

// File: sim/arp_cache_table_core_test.sv
// arp_cache_table_core_test: self-checking bench for the address cache table
// drives the request channel, checks the response channel against a slot-table predictor
// depends on arpc_pkg, arpc_req_if, arpc_rsp_if and the arp_cache_table_core rtl
`default_nettype none

module arp_cache_table_core_test import arpc_pkg::*;;

	localparam int ENTRIES       = 16;
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_WAIT      = 18;

	// operation codes the block does not decode
	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_MID   = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	localparam logic [IP_W-1:0]  IP_ONES  = '1;
	localparam logic [MAC_W-1:0] MAC_ONES = '1;
	localparam logic [IP_W-1:0]  HOST_IP  = 32'hC0A8_0001;
	localparam logic [MAC_W-1:0] HOST_MAC = 48'h0200_5E00_0001;
	localparam logic [IP_W-1:0]  PEER_IP  = 32'h0A00_0001;
	localparam logic [MAC_W-1:0] PEER_MAC = 48'h0011_2233_4455;

	typedef struct packed {
		status_t          status;
		logic [MAC_W-1:0] found_mac;
	} reply_t;

	// one row of the opening sequence; typed_in marks a reply written by hand
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
		logic             typed_in;
		status_t          want_status;
		logic [MAC_W-1:0] want_mac;
	} probe_t;

	localparam int N_OPENING = 24;
	localparam probe_t OPENING_ROWS [N_OPENING] = '{
		// empty table straight after reset
		'{OP_LOOKUP, HOST_IP, 48'h0, 1'b1, ST_NOT_FOUND, 48'h0},
		'{OP_DELETE, PEER_IP, PEER_MAC, 1'b1, ST_NOT_FOUND, 48'h0},
		'{OP_UPDATE, HOST_IP, PEER_MAC, 1'b1, ST_NOT_FOUND, 48'h0},
		// insert before any init lands above the local slot
		'{OP_INSERT, PEER_IP, PEER_MAC, 1'b0, ST_OK, 48'h0},
		'{OP_LOOKUP, PEER_IP, 48'h0, 1'b0, ST_OK, 48'h0},
		// undecoded operations leave the table alone
		'{OP_SPARE_FIRST, PEER_IP, PEER_MAC, 1'b1, ST_NOT_FOUND, 48'h0},
		'{OP_SPARE_MID, 32'h0, 48'h0, 1'b1, ST_NOT_FOUND, 48'h0},
		'{OP_SPARE_LAST, IP_ONES, MAC_ONES, 1'b1, ST_NOT_FOUND, 48'h0},
		// init wipes the peer and loads the local slot
		'{OP_INIT, IP_ONES, MAC_ONES, 1'b1, ST_OK, 48'h0},
		'{OP_LOOKUP, PEER_IP, 48'h0, 1'b1, ST_NOT_FOUND, 48'h0},
		'{OP_LOOKUP, HOST_IP, 48'h0, 1'b0, ST_OK, 48'h0},
		// local slot: duplicate insert refused, delete refused, update allowed
		'{OP_INSERT, HOST_IP, PEER_MAC, 1'b1, ST_PRESENT, 48'h0},
		'{OP_DELETE, HOST_IP, HOST_MAC, 1'b1, ST_NOT_FOUND, 48'h0},
		'{OP_UPDATE, HOST_IP, 48'hAAAA_5555_AAAA, 1'b0, ST_OK, 48'h0},
		'{OP_LOOKUP, HOST_IP, MAC_ONES, 1'b0, ST_OK, 48'h0},
		// field extremes
		'{OP_INSERT, IP_ONES, MAC_ONES, 1'b0, ST_OK, 48'h0},
		'{OP_INSERT, 32'h0, 48'h0, 1'b0, ST_OK, 48'h0},
		'{OP_LOOKUP, IP_ONES, 48'h0, 1'b0, ST_OK, 48'h0},
		'{OP_LOOKUP, 32'h0, MAC_ONES, 1'b0, ST_OK, 48'h0},
		// delete needs the mac to match as well
		'{OP_DELETE, IP_ONES, 48'hFFFF_FFFF_FFFE, 1'b1, ST_NOT_FOUND, 48'h0},
		'{OP_DELETE, IP_ONES, MAC_ONES, 1'b0, ST_OK, 48'h0},
		'{OP_INSERT, 32'h0, 48'h1, 1'b1, ST_PRESENT, 48'h0},
		'{OP_UPDATE, 32'h0, MAC_ONES, 1'b0, ST_OK, 48'h0},
		'{OP_DELETE, 32'h0, MAC_ONES, 1'b0, ST_OK, 48'h0}
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [MAC_W-1:0] cfg_wdata;

	arpc_req_if req_ch ();
	arpc_rsp_if rsp_ch ();

	arp_cache_table_core #(
		.ENTRIES (ENTRIES)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor copy of the cache and of the two host registers
	bit               cache_valid [ENTRIES];
	logic [IP_W-1:0]  cache_ip    [ENTRIES];
	logic [MAC_W-1:0] cache_mac   [ENTRIES];
	logic [IP_W-1:0]  host_ip_copy;
	logic [MAC_W-1:0] host_mac_copy;

	reply_t pending_replies [$];
	int     mismatch_count;
	bit     steady_flow;

	// lowest valid slot holding this ip, -1 when absent
	function automatic int ip_slot(logic [IP_W-1:0] ip);
		for (int i = 0; i < ENTRIES; i++)
			if (cache_valid[i] && cache_ip[i] == ip)
				return i;
		return -1;
	endfunction

	// applies one operation to the predicted table and returns the reply it gives
	function automatic reply_t cache_apply(logic [OP_W-1:0] op, logic [IP_W-1:0] ip,
			logic [MAC_W-1:0] mac);
		reply_t r;
		int     hit;
		r.status    = ST_NOT_FOUND;
		r.found_mac = '0;
		hit = ip_slot(ip);
		case (op)
			OP_LOOKUP: begin
				if (hit >= 0) begin
					r.status    = ST_OK;
					r.found_mac = cache_mac[hit];
				end
			end
			OP_INSERT: begin
				if (hit >= 0) begin
					r.status = ST_PRESENT;
				end else begin
					// the local slot is never a target, even before init
					r.status = ST_FULL;
					for (int i = 1; i < ENTRIES; i++) begin
						if (!cache_valid[i]) begin
							cache_valid[i] = 1'b1;
							cache_ip[i]    = ip;
							cache_mac[i]   = mac;
							r.status       = ST_OK;
							break;
						end
					end
				end
			end
			OP_UPDATE: begin
				if (hit >= 0) begin
					cache_mac[hit] = mac;
					r.status       = ST_OK;
				end
			end
			OP_DELETE: begin
				for (int i = 1; i < ENTRIES; i++) begin
					if (cache_valid[i] && cache_ip[i] == ip && cache_mac[i] == mac) begin
						cache_valid[i] = 1'b0;
						r.status       = ST_OK;
						break;
					end
				end
			end
			OP_INIT: begin
				for (int i = 0; i < ENTRIES; i++)
					cache_valid[i] = 1'b0;
				cache_valid[0] = 1'b1;
				cache_ip[0]    = host_ip_copy;
				cache_mac[0]   = host_mac_copy;
				r.status       = ST_OK;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [31:0] hi;
		logic [31:0] lo;
		hi = $urandom;
		lo = $urandom;
		return {hi[15:0], lo};
	endfunction

	// cycles a side waits before its next transfer; none during a steady stretch
	function automatic int wait_cycles();
		return steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	// both host registers, written back to back; upper bits of the ip word are dropped
	task automatic load_host_regs(logic [MAC_W-1:0] ip_word, logic [MAC_W-1:0] mac);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LOCAL_IP;
		cfg_wdata <= ip_word;
		@(posedge clk);
		cfg_index <= CFG_LOCAL_MAC;
		cfg_wdata <= mac;
		@(posedge clk);
		cfg_we <= 1'b0;
		host_ip_copy  = ip_word[IP_W-1:0];
		host_mac_copy = mac;
	endtask

	// one request transfer; the expected reply is queued on the accepting edge
	task automatic send_request(logic [OP_W-1:0] op, logic [IP_W-1:0] ip,
			logic [MAC_W-1:0] mac, bit typed_in, reply_t typed_reply);
		int     gap;
		reply_t predicted;
		gap = wait_cycles();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.ip_addr   <= ip;
		req_ch.mac_addr  <= mac;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predicted = cache_apply(op, ip, mac);
		pending_replies.push_back(typed_in ? typed_reply : predicted);
	endtask

	// sender holds off until every reply is back and the block has gone quiet
	task automatic drain_replies();
		req_ch.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// random traffic over a pool of addresses; small pools give many hits,
	// large pools with heavy inserts drive the table to full
	task automatic random_phase(int n_items, int pool_n, int insert_pct);
		logic [IP_W-1:0]  ip_pool [$];
		logic [OP_W-1:0]  op;
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
		logic [31:0]      word;
		int               roll;
		int               live [$];
		int               pick;
		reply_t           unused_reply;
		unused_reply = '0;
		ip_pool.push_back(host_ip_copy);
		for (int i = 1; i < pool_n; i++) begin
			word = $urandom;
			ip_pool.push_back(word);
		end
		for (int n = 0; n < n_items; n++) begin
			roll = $urandom_range(0, 99);
			word = $urandom;
			ip   = ip_pool[$urandom_range(0, ip_pool.size() - 1)];
			mac  = rand_mac();
			if (roll < 3) begin
				op = OP_INIT;
			end else if (roll < 6) begin
				word = $urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST);
				op   = word[OP_W-1:0];
			end else if (roll < 6 + insert_pct) begin
				op = OP_INSERT;
				if (roll % 10 == 0)
					ip = word;
			end else begin
				case ($urandom_range(0, 2))
					0: op = OP_LOOKUP;
					1: op = OP_UPDATE;
					default: op = OP_DELETE;
				endcase
				// mostly aim at a live slot, keeping its mac for most deletes
				live.delete();
				for (int i = 0; i < ENTRIES; i++)
					if (cache_valid[i])
						live.push_back(i);
				if (live.size() != 0 && $urandom_range(0, 9) < 7) begin
					pick = live[$urandom_range(0, live.size() - 1)];
					ip   = cache_ip[pick];
					if (op == OP_DELETE && $urandom_range(0, 4) != 0)
						mac = cache_mac[pick];
				end
			end
			send_request(op, ip, mac, 1'b0, unused_reply);
		end
	endtask

	// response side: random back-pressure, every transfer checked in order
	initial begin
		reply_t want;
		int     stall;
		rsp_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = wait_cycles();
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			if (pending_replies.size() == 0) begin
				mismatch_count++;
				$display("%0t: reply with nothing outstanding, status %0d found_mac %h",
					$time, rsp_ch.status, rsp_ch.found_mac);
			end else begin
				want = pending_replies.pop_front();
				if (rsp_ch.status !== want.status) begin
					mismatch_count++;
					$display("%0t: status expected %0d, got %0d", $time, want.status,
						rsp_ch.status);
				end
				if (rsp_ch.found_mac !== want.found_mac) begin
					mismatch_count++;
					$display("%0t: found_mac expected %h, got %h", $time, want.found_mac,
						rsp_ch.found_mac);
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		reply_t row_reply;
		mismatch_count = 0;
		steady_flow    = 1'b0;
		host_ip_copy   = '0;
		host_mac_copy  = '0;
		for (int i = 0; i < ENTRIES; i++)
			cache_valid[i] = 1'b0;
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_LOCAL_IP;
		cfg_wdata        <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= OP_LOOKUP;
		req_ch.ip_addr   <= '0;
		req_ch.mac_addr  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// opening sequence with the host addresses loaded but not yet in the table
		load_host_regs({16'h0, HOST_IP}, HOST_MAC);
		for (int r = 0; r < N_OPENING; r++) begin
			row_reply.status    = OPENING_ROWS[r].want_status;
			row_reply.found_mac = OPENING_ROWS[r].want_mac;
			send_request(OPENING_ROWS[r].op, OPENING_ROWS[r].ip, OPENING_ROWS[r].mac,
				OPENING_ROWS[r].typed_in, row_reply);
		end

		// all-ones host registers, upper bits in the ip word discarded
		drain_replies();
		load_host_regs(MAC_ONES, MAC_ONES);
		random_phase(140, 24, 55);

		// zero host registers, few addresses, no idling on either side
		drain_replies();
		load_host_regs('0, '0);
		steady_flow = 1'b1;
		random_phase(70, 6, 30);
		// hold the sender until the table is quiet, then carry on
		drain_replies();
		random_phase(70, 6, 30);
		steady_flow = 1'b0;

		// random host registers, wide pool and heavy inserts to reach a full table
		drain_replies();
		load_host_regs(rand_mac(), rand_mac());
		random_phase(140, 40, 60);

		// random host registers again, mixed traffic
		drain_replies();
		load_host_regs(rand_mac(), rand_mac());
		random_phase(130, 12, 35);

		drain_replies();
		if (mismatch_count == 0 && pending_replies.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// watchdog, many times the slowest correct run
	initial begin
		#3000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
